[hw/rtl/dpq_pkg.sv]
// ----------------------------------------------------------------------------
// dpq_pkg: shared types and constants of the deadline priority queue
// Task record layout, command, status and register codes, sequencer states.
// ----------------------------------------------------------------------------
package dpq_pkg;

  localparam int ID_W    = 16;
  localparam int IMP_W   = 4;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int KEY_W   = 23;
  localparam int DIFF_W  = KEY_W + 1;
  localparam int LEFT_W  = 23;
  localparam int CFG_W   = 14;

  localparam int DAYS_PER_YEAR  = 365;
  localparam int DAYS_PER_MONTH = 30;

  localparam logic signed [DIFF_W-1:0] LEFT_MAX = DIFF_W'((1 << (LEFT_W - 1)) - 1);
  localparam logic signed [DIFF_W-1:0] LEFT_MIN = -DIFF_W'(1 << (LEFT_W - 1));

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [IMP_W-1:0]   imp;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } task_t;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_PEEK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_TODAY_DAY   = 2'd0,
    REG_TODAY_MONTH = 2'd1,
    REG_TODAY_YEAR  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_WALK,
    S_PUSH_LAST,
    S_DEL_SEARCH,
    S_DEL_SHIFT,
    S_HEAD_RD,
    S_RESULT
  } state_t;

endpackage

[hw/rtl/deadline_priority_queue.sv]
// ----------------------------------------------------------------------------
// deadline_priority_queue: sorted task queue with deadline ordering
// Holds up to QUEUE_DEPTH tasks sorted by date key (earlier first, higher
// importance first on equal keys, new task after equal entries). Runs push,
// pop, delete by id and peek, and reports the head after every command.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  command  | start / busy       | command, task_id, importance, due_*
//  result   | done (1-cycle)     | head_*, head_days_left, entry_count, status
//  config   | cfg_we             | cfg_index, cfg_data
//
//  A command transfers on a rising edge with start high and busy low. Each
//  entry visited takes a turn at the single memory read port and the
//  shared key unit, and busy stays high until the command is through, so a
//  new command waits for the last one to finish.
//  done pulses in the cycle after busy's last high cycle, with busy already
//  low. Reset empties the queue (entry contents stay undefined) and loads
//  today = 1/1/2000. The receiver cannot stall: take the result while done.
// ----------------------------------------------------------------------------
module deadline_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          command,
  input  logic [dpq_pkg::ID_W-1:0]            task_id,
  input  logic [dpq_pkg::IMP_W-1:0]           importance,
  input  logic [dpq_pkg::DAY_W-1:0]           due_day,
  input  logic [dpq_pkg::MONTH_W-1:0]         due_month,
  input  logic [dpq_pkg::YEAR_W-1:0]          due_year,
  // result channel
  output logic                                done,
  output logic                                head_valid,
  output logic [dpq_pkg::ID_W-1:0]            head_id,
  output logic [dpq_pkg::IMP_W-1:0]           head_importance,
  output logic [dpq_pkg::DAY_W-1:0]           head_day,
  output logic [dpq_pkg::MONTH_W-1:0]         head_month,
  output logic [dpq_pkg::YEAR_W-1:0]          head_year,
  output logic signed [dpq_pkg::LEFT_W-1:0]   head_days_left,
  output logic [4:0]                          entry_count,
  output logic [1:0]                          status,
  // configuration port
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [dpq_pkg::CFG_W-1:0]           cfg_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_COUNT  = CW'(1);
  localparam logic [AW-1:0] ONE_IDX    = AW'(1);

  // configured current date
  logic [dpq_pkg::DAY_W-1:0]   today_day;
  logic [dpq_pkg::MONTH_W-1:0] today_month;
  logic [dpq_pkg::YEAR_W-1:0]  today_year;

  // sequencer and datapath registers
  dpq_pkg::state_t  state, state_next;
  logic [AW-1:0]    idx, idx_next;
  logic [AW-1:0]    last_idx, last_idx_next;
  logic [CW-1:0]    count, count_next;
  dpq_pkg::status_t cmd_status, cmd_status_next;
  dpq_pkg::task_t   pend, pend_next;
  logic [dpq_pkg::KEY_W-1:0] new_key, new_key_next;
  logic [dpq_pkg::KEY_W-1:0] today_key, today_key_next;

  // memory port
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  dpq_pkg::task_t mem_wdata;
  logic [AW-1:0]  mem_raddr;
  dpq_pkg::task_t rd_data;

  // shared key unit
  logic [dpq_pkg::YEAR_W-1:0]         ku_year;
  logic [dpq_pkg::MONTH_W-1:0]        ku_month;
  logic [dpq_pkg::DAY_W-1:0]          ku_day;
  logic [dpq_pkg::IMP_W-1:0]          ku_imp;
  logic [dpq_pkg::KEY_W-1:0]          ku_ref_key;
  logic [dpq_pkg::KEY_W-1:0]          ku_key;
  logic signed [dpq_pkg::DIFF_W-1:0]  ku_diff;
  logic                               ku_later;

  logic            accept;
  logic            q_empty, q_full, at_last, id_match;
  dpq_pkg::cmd_t   cmd;
  dpq_pkg::task_t  in_task;
  logic signed [dpq_pkg::LEFT_W-1:0] left_sat;

  assign busy     = (state != dpq_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign cmd      = dpq_pkg::cmd_t'(command);
  assign q_empty  = (count == '0);
  assign q_full   = (count == FULL_COUNT);
  assign at_last  = (idx == last_idx);
  assign id_match = (rd_data.id == pend.id);

  assign in_task = '{id: task_id, imp: importance, day: due_day,
                     month: due_month, year: due_year};

  // configuration writes; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      today_day   <= dpq_pkg::DAY_W'(1);
      today_month <= dpq_pkg::MONTH_W'(1);
      today_year  <= dpq_pkg::YEAR_W'(2000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpq_pkg::REG_TODAY_DAY:   today_day   <= cfg_data[dpq_pkg::DAY_W-1:0];
        dpq_pkg::REG_TODAY_MONTH: today_month <= cfg_data[dpq_pkg::MONTH_W-1:0];
        dpq_pkg::REG_TODAY_YEAR:  today_year  <= cfg_data[dpq_pkg::YEAR_W-1:0];
        default: ;
      endcase
    end
  end

  // key unit operands: incoming task on accept, today's date before the
  // head read, the entry just read otherwise
  always_comb begin
    unique case (state)
      dpq_pkg::S_IDLE: begin
        ku_year  = due_year;
        ku_month = due_month;
        ku_day   = due_day;
        ku_imp   = importance;
      end
      dpq_pkg::S_HEAD_RD: begin
        ku_year  = today_year;
        ku_month = today_month;
        ku_day   = today_day;
        ku_imp   = '0;
      end
      default: begin
        ku_year  = rd_data.year;
        ku_month = rd_data.month;
        ku_day   = rd_data.day;
        ku_imp   = rd_data.imp;
      end
    endcase
  end

  assign ku_ref_key = (state == dpq_pkg::S_RESULT) ? today_key : new_key;

  dpq_key_unit u_key (
    .year    (ku_year),
    .month   (ku_month),
    .day     (ku_day),
    .imp     (ku_imp),
    .ref_key (ku_ref_key),
    .ref_imp (pend.imp),
    .key     (ku_key),
    .diff    (ku_diff),
    .later   (ku_later)
  );

  dpq_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dpq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            dpq_pkg::CMD_PUSH:
              state_next = (q_empty || q_full) ? dpq_pkg::S_HEAD_RD : dpq_pkg::S_PUSH_WALK;
            dpq_pkg::CMD_POP:
              state_next = (count <= ONE_COUNT) ? dpq_pkg::S_HEAD_RD : dpq_pkg::S_DEL_SHIFT;
            dpq_pkg::CMD_DELETE:
              state_next = q_empty ? dpq_pkg::S_HEAD_RD : dpq_pkg::S_DEL_SEARCH;
            dpq_pkg::CMD_PEEK:
              state_next = dpq_pkg::S_HEAD_RD;
          endcase
        end
      end
      dpq_pkg::S_PUSH_WALK: begin
        priority if (!ku_later) state_next = dpq_pkg::S_HEAD_RD;
        else if (idx == '0)     state_next = dpq_pkg::S_PUSH_LAST;
        else                    state_next = dpq_pkg::S_PUSH_WALK;
      end
      dpq_pkg::S_PUSH_LAST: state_next = dpq_pkg::S_HEAD_RD;
      dpq_pkg::S_DEL_SEARCH: begin
        priority if (at_last) state_next = dpq_pkg::S_HEAD_RD;
        else if (id_match)    state_next = dpq_pkg::S_DEL_SHIFT;
        else                  state_next = dpq_pkg::S_DEL_SEARCH;
      end
      dpq_pkg::S_DEL_SHIFT: begin
        if (at_last) state_next = dpq_pkg::S_HEAD_RD;
      end
      dpq_pkg::S_HEAD_RD: state_next = dpq_pkg::S_RESULT;
      dpq_pkg::S_RESULT:  state_next = dpq_pkg::S_IDLE;
      default:            state_next = dpq_pkg::S_IDLE;
    endcase
  end

  // memory controls and datapath register updates
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = idx + ONE_IDX;
    mem_wdata       = pend;
    mem_raddr       = idx + ONE_IDX;
    idx_next        = idx;
    last_idx_next   = last_idx;
    count_next      = count;
    cmd_status_next = cmd_status;
    pend_next       = pend;
    new_key_next    = new_key;
    today_key_next  = today_key;
    unique case (state)
      dpq_pkg::S_IDLE: begin
        if (accept) begin
          pend_next       = in_task;
          new_key_next    = ku_key;
          last_idx_next   = AW'(count - ONE_COUNT);
          cmd_status_next = dpq_pkg::ST_OK;
          if (cmd == dpq_pkg::CMD_PUSH) begin
            priority if (q_full) begin
              cmd_status_next = dpq_pkg::ST_FULL;
            end else if (q_empty) begin
              count_next = count + ONE_COUNT;
              mem_we     = 1'b1;
              mem_waddr  = '0;
              mem_wdata  = in_task;
            end else begin
              // walk down from the tail, moving later entries up by one
              count_next = count + ONE_COUNT;
              mem_raddr  = AW'(count - ONE_COUNT);
              idx_next   = AW'(count - ONE_COUNT);
            end
          end else if (q_empty) begin
            cmd_status_next = dpq_pkg::ST_EMPTY;
          end else if (cmd == dpq_pkg::CMD_POP) begin
            count_next = count - ONE_COUNT;
            mem_raddr  = ONE_IDX;
            idx_next   = ONE_IDX;
          end else if (cmd == dpq_pkg::CMD_DELETE) begin
            mem_raddr = '0;
            idx_next  = '0;
          end
        end
      end
      dpq_pkg::S_PUSH_WALK: begin
        mem_we = 1'b1;
        if (ku_later) begin
          mem_wdata = rd_data;
          mem_raddr = idx - ONE_IDX;
          idx_next  = idx - ONE_IDX;
        end
      end
      dpq_pkg::S_PUSH_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
      end
      dpq_pkg::S_DEL_SEARCH: begin
        if (id_match) begin
          count_next = count - ONE_COUNT;
        end else if (at_last) begin
          cmd_status_next = dpq_pkg::ST_NOT_FOUND;
        end
        if (!at_last) begin
          idx_next = idx + ONE_IDX;
        end
      end
      dpq_pkg::S_DEL_SHIFT: begin
        // close the gap: move each later entry down by one
        mem_we    = 1'b1;
        mem_waddr = idx - ONE_IDX;
        mem_wdata = rd_data;
        if (!at_last) begin
          idx_next = idx + ONE_IDX;
        end
      end
      dpq_pkg::S_HEAD_RD: begin
        mem_raddr      = '0;
        today_key_next = ku_key;
      end
      dpq_pkg::S_RESULT: ;
      default: ;
    endcase
  end

  // saturate head key minus today's key to the result width
  always_comb begin
    priority if (ku_diff > dpq_pkg::LEFT_MAX) begin
      left_sat = dpq_pkg::LEFT_W'(dpq_pkg::LEFT_MAX);
    end else if (ku_diff < dpq_pkg::LEFT_MIN) begin
      left_sat = dpq_pkg::LEFT_W'(dpq_pkg::LEFT_MIN);
    end else begin
      left_sat = ku_diff[dpq_pkg::LEFT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpq_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == dpq_pkg::S_RESULT);
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    last_idx   <= last_idx_next;
    cmd_status <= cmd_status_next;
    pend       <= pend_next;
    new_key    <= new_key_next;
    today_key  <= today_key_next;
  end

  // load the result; an empty queue reports all head fields as zero
  always_ff @(posedge clk) begin
    if (state == dpq_pkg::S_RESULT) begin
      entry_count <= 5'(count);
      status      <= cmd_status;
      if (q_empty) begin
        head_valid      <= 1'b0;
        head_id         <= '0;
        head_importance <= '0;
        head_day        <= '0;
        head_month      <= '0;
        head_year       <= '0;
        head_days_left  <= '0;
      end else begin
        head_valid      <= 1'b1;
        head_id         <= rd_data.id;
        head_importance <= rd_data.imp;
        head_day        <= rd_data.day;
        head_month      <= rd_data.month;
        head_year       <= rd_data.year;
        head_days_left  <= left_sat;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == dpq_pkg::S_RESULT))
    else $error("result strobe without a finished command");

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == dpq_pkg::CMD_PUSH && q_full) |=> (count == FULL_COUNT))
    else $error("push into full queue changed the count");

  a_head_valid_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (head_valid == (count != '0)))
    else $error("head_valid disagrees with the entry count");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == dpq_pkg::S_DEL_SEARCH || state == dpq_pkg::S_DEL_SHIFT)
      |-> (idx <= last_idx))
    else $error("delete walk ran past the tail");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == dpq_pkg::S_PUSH_WALK) |-> (count <= FULL_COUNT && idx < last_idx + ONE_IDX))
    else $error("push walk outside the held entries");
`endif

endmodule

[hw/rtl/dpq_key_unit.sv]
// ----------------------------------------------------------------------------
// dpq_key_unit: shared date key, subtract and order compare
// Forms year*365 + month*30 + day, subtracts a reference key and tells
// whether the entry sorts after the reference task.
// ----------------------------------------------------------------------------
module dpq_key_unit (
  input  logic [dpq_pkg::YEAR_W-1:0]         year,
  input  logic [dpq_pkg::MONTH_W-1:0]        month,
  input  logic [dpq_pkg::DAY_W-1:0]          day,
  input  logic [dpq_pkg::IMP_W-1:0]          imp,
  input  logic [dpq_pkg::KEY_W-1:0]          ref_key,
  input  logic [dpq_pkg::IMP_W-1:0]          ref_imp,
  output logic [dpq_pkg::KEY_W-1:0]          key,
  output logic signed [dpq_pkg::DIFF_W-1:0]  diff,
  output logic                               later
);

  localparam logic [dpq_pkg::KEY_W-1:0] YEAR_MUL  = dpq_pkg::KEY_W'(dpq_pkg::DAYS_PER_YEAR);
  localparam logic [dpq_pkg::KEY_W-1:0] MONTH_MUL = dpq_pkg::KEY_W'(dpq_pkg::DAYS_PER_MONTH);

  assign key = dpq_pkg::KEY_W'(year) * YEAR_MUL
             + dpq_pkg::KEY_W'(month) * MONTH_MUL
             + dpq_pkg::KEY_W'(day);

  assign diff = $signed({1'b0, key}) - $signed({1'b0, ref_key});

  // strictly after: later date, or same date and lower importance
  assign later = (diff > 0) || ((diff == 0) && (imp < ref_imp));

endmodule

[hw/rtl/dpq_store.sv]
// ----------------------------------------------------------------------------
// dpq_store: task entry memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dpq_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  dpq_pkg::task_t   wdata,
  input  logic [AW-1:0]    raddr,
  output dpq_pkg::task_t   rdata
);

  dpq_pkg::task_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[dv/deadline_priority_queue_tb.sv]
// ----------------------------------------------------------------------------
// deadline_priority_queue_tb: self-checking bench for the deadline queue
// Drives push, pop, delete and peek commands with random gaps, keeps a shadow
// copy of the sorted queue and of the current date, and checks every head
// report field by field against the shadow copy in transfer order.
// ----------------------------------------------------------------------------
module deadline_priority_queue_tb;

  localparam int QUEUE_DEPTH = 16;
  // Neither the slowest command nor the longest gap the sender leaves comes
  // near QUIET_LIMIT, so a silence that long can only mean a hang.
  localparam int QUIET_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int PHASE_COUNT = 8;
  localparam longint DAYS_LEFT_MAX = 4194303;
  localparam longint DAYS_LEFT_MIN = -4194304;

  // One head report, as the block should present it on done.
  typedef struct {
    logic                              valid;
    logic [dpq_pkg::ID_W-1:0]          id;
    logic [dpq_pkg::IMP_W-1:0]         imp;
    logic [dpq_pkg::DAY_W-1:0]         day;
    logic [dpq_pkg::MONTH_W-1:0]       month;
    logic [dpq_pkg::YEAR_W-1:0]        year;
    logic signed [dpq_pkg::LEFT_W-1:0] days_left;
    logic [4:0]                        count;
    dpq_pkg::status_t                  st;
  } head_report_t;

  // Every input holds a known value from time zero.
  logic                                clk;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                busy;
  logic [1:0]                          command = dpq_pkg::CMD_PEEK;
  logic [dpq_pkg::ID_W-1:0]            task_id = '0;
  logic [dpq_pkg::IMP_W-1:0]           importance = '0;
  logic [dpq_pkg::DAY_W-1:0]           due_day = '0;
  logic [dpq_pkg::MONTH_W-1:0]         due_month = '0;
  logic [dpq_pkg::YEAR_W-1:0]          due_year = '0;
  logic                                done;
  logic                                head_valid;
  logic [dpq_pkg::ID_W-1:0]            head_id;
  logic [dpq_pkg::IMP_W-1:0]           head_importance;
  logic [dpq_pkg::DAY_W-1:0]           head_day;
  logic [dpq_pkg::MONTH_W-1:0]         head_month;
  logic [dpq_pkg::YEAR_W-1:0]          head_year;
  logic signed [dpq_pkg::LEFT_W-1:0]   head_days_left;
  logic [4:0]                          entry_count;
  logic [1:0]                          status;
  logic                                cfg_we = 1'b0;
  logic [1:0]                          cfg_index = dpq_pkg::REG_TODAY_DAY;
  logic [dpq_pkg::CFG_W-1:0]           cfg_data = '0;

  // Shadow queue, updated at each transfer, and current date, updated at each configuration write.
  dpq_pkg::task_t                      shadow_tasks [QUEUE_DEPTH];
  int                                  shadow_count = 0;
  logic [dpq_pkg::DAY_W-1:0]           today_day_q = 5'd1;
  logic [dpq_pkg::MONTH_W-1:0]         today_month_q = 4'd1;
  logic [dpq_pkg::YEAR_W-1:0]          today_year_q = 14'd2000;

  head_report_t                        expected_heads [$];
  int                                  mismatch_count = 0;
  int                                  quiet_cycles = 0;
  bit                                  gaps_on = 1'b1;

  deadline_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .task_id(task_id),
    .importance(importance),
    .due_day(due_day),
    .due_month(due_month),
    .due_year(due_year),
    .done(done),
    .head_valid(head_valid),
    .head_id(head_id),
    .head_importance(head_importance),
    .head_day(head_day),
    .head_month(head_month),
    .head_year(head_year),
    .head_days_left(head_days_left),
    .entry_count(entry_count),
    .status(status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow model of the sorted queue
  // --------------------------------------------------------------------------

  function automatic int deadline_key(input logic [dpq_pkg::YEAR_W-1:0] y,
                                      input logic [dpq_pkg::MONTH_W-1:0] m,
                                      input logic [dpq_pkg::DAY_W-1:0] d);
    return int'(y) * dpq_pkg::DAYS_PER_YEAR + int'(m) * dpq_pkg::DAYS_PER_MONTH
         + int'(d);
  endfunction

  function automatic void drop_shadow_entry(input int pos);
    int i;
    for (i = pos; i + 1 < shadow_count; i++)
      shadow_tasks[i] = shadow_tasks[i + 1];
    shadow_count--;
  endfunction

  // Apply one transferred command to the shadow queue and queue up the head
  // report the block must give for it.
  function automatic void advance_shadow_queue(input dpq_pkg::cmd_t op,
                                               input dpq_pkg::task_t t);
    head_report_t     rep;
    dpq_pkg::status_t st;
    int               pos;
    int               i;
    int               new_key;
    int               old_key;
    bit               hit;
    longint           left;
    st = dpq_pkg::ST_OK;
    hit = 1'b0;
    if (op == dpq_pkg::CMD_PUSH) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        st = dpq_pkg::ST_FULL;
      end else begin
        // Land the new task after every entry that ties on key and importance.
        new_key = deadline_key(t.year, t.month, t.day);
        pos = shadow_count;
        for (i = 0; i < shadow_count; i++) begin
          old_key = deadline_key(shadow_tasks[i].year, shadow_tasks[i].month,
                                 shadow_tasks[i].day);
          if (!hit && (old_key > new_key ||
                       (old_key == new_key && shadow_tasks[i].imp < t.imp))) begin
            pos = i;
            hit = 1'b1;
          end
        end
        for (i = shadow_count; i > pos; i--)
          shadow_tasks[i] = shadow_tasks[i - 1];
        shadow_tasks[pos] = t;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      st = dpq_pkg::ST_EMPTY;
    end else if (op == dpq_pkg::CMD_POP) begin
      drop_shadow_entry(0);
    end else if (op == dpq_pkg::CMD_DELETE) begin
      // Remove only the first entry carrying the id.
      for (i = 0; i < shadow_count; i++) begin
        if (!hit && shadow_tasks[i].id == t.id) begin
          pos = i;
          hit = 1'b1;
        end
      end
      if (hit) drop_shadow_entry(pos);
      else st = dpq_pkg::ST_NOT_FOUND;
    end

    // An empty queue reports zero in every head field.
    rep.valid = 1'b0;
    rep.id = '0;
    rep.imp = '0;
    rep.day = '0;
    rep.month = '0;
    rep.year = '0;
    rep.days_left = '0;
    if (shadow_count > 0) begin
      left = longint'(deadline_key(shadow_tasks[0].year, shadow_tasks[0].month,
                                   shadow_tasks[0].day))
           - longint'(deadline_key(today_year_q, today_month_q, today_day_q));
      if (left > DAYS_LEFT_MAX) left = DAYS_LEFT_MAX;
      if (left < DAYS_LEFT_MIN) left = DAYS_LEFT_MIN;
      rep.valid = 1'b1;
      rep.id = shadow_tasks[0].id;
      rep.imp = shadow_tasks[0].imp;
      rep.day = shadow_tasks[0].day;
      rep.month = shadow_tasks[0].month;
      rep.year = shadow_tasks[0].year;
      rep.days_left = dpq_pkg::LEFT_W'(left);
    end
    rep.count = 5'(shadow_count);
    rep.st = st;
    expected_heads.push_back(rep);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Send one command and return in the time step of its transfer, with start
  // still high: the next call either keeps it high or lowers it, so start
  // never gets two assignments in one step.
  task automatic issue_command(input dpq_pkg::cmd_t op, input dpq_pkg::task_t t);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= op;
    task_id <= t.id;
    importance <= t.imp;
    due_day <= t.day;
    due_month <= t.month;
    due_year <= t.year;
    @(posedge clk);
    while (busy) @(posedge clk);
    advance_shadow_queue(op, t);
  endtask

  task automatic program_reg(input dpq_pkg::cfg_reg_t idx,
                             input logic [dpq_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      dpq_pkg::REG_TODAY_DAY:   today_day_q = value[dpq_pkg::DAY_W-1:0];
      dpq_pkg::REG_TODAY_MONTH: today_month_q = value[dpq_pkg::MONTH_W-1:0];
      dpq_pkg::REG_TODAY_YEAR:  today_year_q = value[dpq_pkg::YEAR_W-1:0];
      default: ;
    endcase
  endtask

  // Change the date only once the block has drained: every report is in and,
  // since done comes with busy low, nothing is in flight.
  task automatic set_today(input logic [dpq_pkg::CFG_W-1:0] d,
                           input logic [dpq_pkg::CFG_W-1:0] m,
                           input logic [dpq_pkg::CFG_W-1:0] y);
    start <= 1'b0;
    while (expected_heads.size() != 0) @(posedge clk);
    program_reg(dpq_pkg::REG_TODAY_DAY, d);
    program_reg(dpq_pkg::REG_TODAY_MONTH, m);
    program_reg(dpq_pkg::REG_TODAY_YEAR, y);
    cfg_we <= 1'b0;
  endtask

  // Mostly tightly clustered dates and ids, so that ties and repeated ids are
  // common; some in-range dates; a few raw bit patterns beyond the ranges.
  function automatic dpq_pkg::task_t random_task();
    dpq_pkg::task_t t;
    int unsigned    mode;
    mode = $urandom_range(0, 9);
    t.id = ($urandom_range(0, 3) == 0) ? dpq_pkg::ID_W'($urandom)
                                       : dpq_pkg::ID_W'($urandom_range(0, 15));
    if (mode < 6) begin
      t.imp = dpq_pkg::IMP_W'($urandom_range(0, 3));
      t.day = dpq_pkg::DAY_W'($urandom_range(1, 3));
      t.month = dpq_pkg::MONTH_W'($urandom_range(1, 2));
      t.year = dpq_pkg::YEAR_W'($urandom_range(2000, 2001));
    end else if (mode < 9) begin
      t.imp = dpq_pkg::IMP_W'($urandom_range(0, 9));
      t.day = dpq_pkg::DAY_W'($urandom_range(1, 31));
      t.month = dpq_pkg::MONTH_W'($urandom_range(1, 12));
      t.year = dpq_pkg::YEAR_W'($urandom_range(0, 9999));
    end else begin
      t.imp = dpq_pkg::IMP_W'($urandom);
      t.day = dpq_pkg::DAY_W'($urandom);
      t.month = dpq_pkg::MONTH_W'($urandom);
      t.year = dpq_pkg::YEAR_W'($urandom);
    end
    return t;
  endfunction

  // Filling traffic leans on pushes, draining traffic on pops and deletes;
  // most deletes aim at an id that is held.
  task automatic issue_random_command(input bit filling);
    dpq_pkg::task_t t;
    dpq_pkg::cmd_t  op;
    int unsigned    roll;
    t = random_task();
    roll = $urandom_range(0, 99);
    if (roll < (filling ? 60 : 25)) op = dpq_pkg::CMD_PUSH;
    else if (roll < (filling ? 72 : 55)) op = dpq_pkg::CMD_POP;
    else if (roll < (filling ? 88 : 85)) op = dpq_pkg::CMD_DELETE;
    else op = dpq_pkg::CMD_PEEK;
    if (op == dpq_pkg::CMD_DELETE && shadow_count > 0 && $urandom_range(0, 3) != 0)
      t.id = shadow_tasks[$urandom_range(0, shadow_count - 1)].id;
    issue_command(op, t);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // A report lives for one cycle only; take it at the edge that ends it.
  always @(posedge clk) begin : check_head_reports
    head_report_t want;
    if (!rst && done) begin
      if (expected_heads.size() == 0) begin
        flag_mismatch("report with no command outstanding", 64'(status), 64'(0));
      end else begin
        want = expected_heads.pop_front();
        if (head_valid !== want.valid)
          flag_mismatch("head_valid", 64'(head_valid), 64'(want.valid));
        if (head_id !== want.id) flag_mismatch("head_id", 64'(head_id), 64'(want.id));
        if (head_importance !== want.imp)
          flag_mismatch("head_importance", 64'(head_importance), 64'(want.imp));
        if (head_day !== want.day) flag_mismatch("head_day", 64'(head_day), 64'(want.day));
        if (head_month !== want.month)
          flag_mismatch("head_month", 64'(head_month), 64'(want.month));
        if (head_year !== want.year)
          flag_mismatch("head_year", 64'(head_year), 64'(want.year));
        if (head_days_left !== want.days_left)
          flag_mismatch("head_days_left", 64'(head_days_left), 64'(want.days_left));
        if (entry_count !== want.count)
          flag_mismatch("entry_count", 64'(entry_count), 64'(want.count));
        if (status !== want.st) flag_mismatch("status", 64'(status), 64'(want.st));
      end
    end
  end

  // Count cycles without any transfer; a hang ends the run.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Pop, delete and peek on an empty queue change nothing.
  task automatic test_empty_queue();
    issue_command(dpq_pkg::CMD_PEEK, random_task());
    issue_command(dpq_pkg::CMD_POP, random_task());
    issue_command(dpq_pkg::CMD_DELETE, random_task());
  endtask

  // All-ones fields saturate days left upward; all-zero fields take the head.
  task automatic test_extreme_fields();
    dpq_pkg::task_t t;
    t.id = '1;
    t.imp = '1;
    t.day = '1;
    t.month = '1;
    t.year = '1;
    issue_command(dpq_pkg::CMD_PUSH, t);
    t.id = '0;
    t.imp = '0;
    t.day = '0;
    t.month = '0;
    t.year = '0;
    issue_command(dpq_pkg::CMD_PUSH, t);
  endtask

  // Equal keys: higher importance first, equal importance in arrival order,
  // and one key reached through a different month/day split. Pop through
  // the run to expose the order, then delete an entry behind the head.
  task automatic test_tie_order();
    dpq_pkg::task_t t;
    t.year = 14'd2001;
    t.month = 4'd1;
    t.day = 5'd30;
    t.imp = 4'd5;
    t.id = 16'h0A0A;
    issue_command(dpq_pkg::CMD_PUSH, t);
    t.id = 16'h0B0B;
    issue_command(dpq_pkg::CMD_PUSH, t);
    t.id = 16'h0C0C;
    t.imp = 4'd7;
    issue_command(dpq_pkg::CMD_PUSH, t);
    t.id = 16'h0D0D;
    t.imp = 4'd5;
    t.month = 4'd2;
    t.day = 5'd0;
    issue_command(dpq_pkg::CMD_PUSH, t);
    repeat (3) issue_command(dpq_pkg::CMD_POP, t);
    issue_command(dpq_pkg::CMD_DELETE, t);
  endtask

  // Delete an id that no entry holds.
  task automatic test_delete_absent();
    dpq_pkg::task_t t;
    bit             held;
    int             i;
    t = random_task();
    do begin
      t.id = dpq_pkg::ID_W'($urandom);
      held = 1'b0;
      for (i = 0; i < shadow_count; i++)
        if (shadow_tasks[i].id == t.id) held = 1'b1;
    end while (held);
    issue_command(dpq_pkg::CMD_DELETE, t);
  endtask

  // Fill to capacity, then push once more: the extra task is dropped.
  task automatic test_fill_overflow();
    while (shadow_count < QUEUE_DEPTH) issue_command(dpq_pkg::CMD_PUSH, random_task());
    issue_command(dpq_pkg::CMD_PUSH, random_task());
    issue_command(dpq_pkg::CMD_PEEK, random_task());
  endtask

  // Date extremes: the largest date saturates days left downward, the zero
  // date gives a large positive count, then the ends of the stated ranges.
  task automatic test_today_settings();
    set_today('1, '1, '1);
    issue_command(dpq_pkg::CMD_PEEK, random_task());
    set_today(dpq_pkg::CFG_W'(0), dpq_pkg::CFG_W'(0), dpq_pkg::CFG_W'(0));
    issue_command(dpq_pkg::CMD_PEEK, random_task());
    set_today(dpq_pkg::CFG_W'(1), dpq_pkg::CFG_W'(1), dpq_pkg::CFG_W'(0));
    issue_command(dpq_pkg::CMD_PEEK, random_task());
    set_today(dpq_pkg::CFG_W'(31), dpq_pkg::CFG_W'(12), dpq_pkg::CFG_W'(9999));
    issue_command(dpq_pkg::CMD_PEEK, random_task());
  endtask

  // Phases alternate filling and draining traffic, each with its own date;
  // every third phase runs without gaps.
  task automatic test_random_traffic();
    int p;
    for (p = 0; p < PHASE_COUNT; p++) begin
      if (p == 0)
        set_today(dpq_pkg::CFG_W'(1), dpq_pkg::CFG_W'(1), dpq_pkg::CFG_W'(2000));
      else if (p % 4 == 3)
        set_today(dpq_pkg::CFG_W'($urandom), dpq_pkg::CFG_W'($urandom),
                  dpq_pkg::CFG_W'($urandom));
      else
        set_today(dpq_pkg::CFG_W'($urandom_range(1, 31)),
                  dpq_pkg::CFG_W'($urandom_range(1, 12)),
                  dpq_pkg::CFG_W'($urandom_range(1998, 2003)));
      gaps_on = (p % 3 != 1);
      repeat (ITEMS_PER_PHASE) issue_random_command(p % 2 == 0);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_extreme_fields();
    test_tie_order();
    test_delete_absent();
    test_fill_overflow();
    test_today_settings();
    test_random_traffic();
    // Drop start, drain the outstanding reports, then hold a little longer
    // to catch any stray report.
    start <= 1'b0;
    while (expected_heads.size() != 0) @(posedge clk);
    repeat (QUEUE_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
